>>> rtl/clfp_pkg.sv
// ----------------------------------------------------------------------------
// clfp_pkg: shared types and constants for the call-log frame parser
// Holds the result kinds, the stream constants, the classified byte record
// that travels from the front end through the queue, and the default depth
// of that queue.
// ----------------------------------------------------------------------------
package clfp_pkg;

	localparam int unsigned QueueDepthDefault = 4;

	localparam logic [7:0] HeaderLead   = 8'd208;
	localparam logic [3:0] MarkerNibble = 4'hd;
	localparam logic [7:0] DateLength   = 8'd6;
	localparam logic [7:0] HeaderLength = 8'd6;

	// Header byte indexes that are compared against a fixed value.
	localparam logic [7:0] HdrIdxLead  = 8'd0;
	localparam logic [7:0] HdrIdxOne   = 8'd1;
	localparam logic [7:0] HdrIdxZero  = 8'd3;
	localparam logic [7:0] HdrIdxFinal = 8'd5;

	typedef enum logic [2:0] {
		KIND_NAME   = 3'd0,
		KIND_NUMBER = 3'd1,
		KIND_STATE  = 3'd2,
		KIND_DATE   = 3'd3,
		KIND_REC    = 3'd4,
		KIND_ERROR  = 3'd5,
		KIND_DONE   = 3'd6
	} kind_t;

	// One request after classification by the front end.
	typedef struct packed {
		logic [7:0] data;
		logic       eoi;
		logic       marker;
		logic       is_lead;
		logic       is_zero;
		logic       is_one;
		logic       state_ok;
		logic [1:0] state_code;
	} class_t;

endpackage

>>> rtl/clfp_front.sv
// ----------------------------------------------------------------------------
// clfp_front: request classifier
// Tags each incoming byte with the comparisons the parser needs (marker,
// header values, call-state decode) so the back end only steers on flags.
// ----------------------------------------------------------------------------
module clfp_front (
	input  logic [7:0]      byte_value,
	input  logic            end_of_input,
	output clfp_pkg::class_t cls
);
	import clfp_pkg::*;

	always_comb begin
		cls            = '0;
		cls.data       = byte_value;
		cls.eoi        = end_of_input;
		cls.marker     = (byte_value[7:4] == MarkerNibble);
		cls.is_lead    = (byte_value == HeaderLead);
		cls.is_zero    = (byte_value == 8'd0);
		cls.is_one     = (byte_value == 8'd1);
		cls.state_ok   = 1'b1;
		cls.state_code = 2'd0;
		case (byte_value)
			8'd1, 8'd33: cls.state_code = 2'd0;
			8'd2, 8'd34: cls.state_code = 2'd1;
			8'd3, 8'd35: cls.state_code = 2'd2;
			default: cls.state_ok = 1'b0;
		endcase
	end

endmodule

>>> rtl/clfp_queue.sv
// ----------------------------------------------------------------------------
// clfp_queue: short request queue between front and back end
// Register-based FIFO; depth is a power of two of at least two.
// ----------------------------------------------------------------------------
module clfp_queue #(
	parameter int unsigned DEPTH = clfp_pkg::QueueDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  clfp_pkg::class_t wr_data,
	input  logic             pop,
	output clfp_pkg::class_t rd_data,
	output logic             full,
	output logic             empty
);
	import clfp_pkg::*;

	localparam int unsigned PtrW = $clog2(DEPTH);
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	class_t            store_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/clfp_back.sv
// ----------------------------------------------------------------------------
// clfp_back: parser state machine and result register
// Consumes one request per cycle while its output register is free or taken,
// walks the header and record fields, and loads at most one result into it.
// ----------------------------------------------------------------------------
module clfp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  clfp_pkg::class_t cls,
	input  logic             avail,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       kind,
	output logic [7:0]       value,
	output logic [7:0]       position
);
	import clfp_pkg::*;

	typedef enum logic [13:0] {
		PH_HEADER   = 14'b00000000000001,
		PH_NAME_LEN = 14'b00000000000010,
		PH_NAME     = 14'b00000000000100,
		PH_STATE    = 14'b00000000001000,
		PH_STATE_M  = 14'b00000000010000,
		PH_NUM_LEN  = 14'b00000000100000,
		PH_NUM      = 14'b00000001000000,
		PH_DATE     = 14'b00000010000000,
		PH_TR0      = 14'b00000100000000,
		PH_TR_M1    = 14'b00001000000000,
		PH_TR1      = 14'b00010000000000,
		PH_TR_LAST  = 14'b00100000000000,
		PH_DONE     = 14'b01000000000000,
		PH_ERROR    = 14'b10000000000000
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] count_q, count_d;
	logic [7:0] flen_q, flen_d;
	logic [8:0] count_inc;
	logic       hdr_ok;
	logic       emit;
	kind_t      kind_d;
	logic [7:0] value_d;
	logic [7:0] pos_d;
	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] value_q;
	logic [7:0] pos_q;

	assign pop       = avail && (!out_valid_q || out_ready);
	assign count_inc = {1'b0, count_q} + 9'd1;
	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign position  = pos_q;

	always_comb begin
		case (count_q)
			HdrIdxLead:  hdr_ok = cls.is_lead;
			HdrIdxOne:   hdr_ok = cls.is_one;
			HdrIdxZero:  hdr_ok = cls.is_zero;
			HdrIdxFinal: hdr_ok = cls.is_one;
			default:     hdr_ok = 1'b1;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		flen_d  = flen_q;
		emit    = 1'b0;
		kind_d  = KIND_ERROR;
		value_d = 8'd0;
		pos_d   = 8'd0;
		if (phase_q == PH_DONE || phase_q == PH_ERROR) begin
			phase_d = phase_q;
		end else if (cls.eoi) begin
			emit = 1'b1;
			if (phase_q == PH_TR0) begin
				phase_d = PH_DONE;
				kind_d  = KIND_DONE;
			end else begin
				phase_d = PH_ERROR;
			end
		end else begin
			case (phase_q)
				PH_HEADER: begin
					if (!hdr_ok) begin
						emit    = 1'b1;
						phase_d = PH_ERROR;
					end else if (count_inc >= {1'b0, HeaderLength}) begin
						phase_d = PH_NAME_LEN;
						count_d = 8'd0;
					end else begin
						count_d = count_inc[7:0];
					end
				end
				PH_NAME_LEN, PH_NUM_LEN: begin
					flen_d  = cls.data;
					count_d = 8'd0;
					if (phase_q == PH_NAME_LEN) begin
						phase_d = cls.is_zero ? PH_STATE : PH_NAME;
					end else begin
						phase_d = cls.is_zero ? PH_DATE : PH_NUM;
					end
				end
				PH_NAME, PH_NUM, PH_DATE: begin
					if (!cls.marker) begin
						emit    = 1'b1;
						value_d = cls.data;
						pos_d   = count_q;
						kind_d  = (phase_q == PH_NAME) ? KIND_NAME :
							(phase_q == PH_NUM) ? KIND_NUMBER : KIND_DATE;
						if (phase_q == PH_DATE) begin
							if (count_inc >= {1'b0, DateLength}) begin
								phase_d = PH_TR0;
								count_d = 8'd0;
							end else begin
								count_d = count_inc[7:0];
							end
						end else if (count_inc >= {1'b0, flen_q}) begin
							phase_d = (phase_q == PH_NAME) ? PH_STATE : PH_DATE;
							count_d = 8'd0;
						end else begin
							count_d = count_inc[7:0];
						end
					end
				end
				PH_STATE, PH_STATE_M: begin
					if (phase_q == PH_STATE && cls.marker) begin
						phase_d = PH_STATE_M;
					end else begin
						emit = 1'b1;
						if (cls.state_ok) begin
							kind_d  = KIND_STATE;
							value_d = {6'd0, cls.state_code};
							phase_d = PH_NUM_LEN;
							count_d = 8'd0;
						end else begin
							phase_d = PH_ERROR;
						end
					end
				end
				PH_TR0: begin
					phase_d = cls.marker ? PH_TR_M1 : PH_TR1;
				end
				PH_TR_M1: begin
					phase_d = PH_TR_LAST;
				end
				PH_TR1, PH_TR_LAST: begin
					if (phase_q == PH_TR1 && cls.marker) begin
						phase_d = PH_TR_LAST;
					end else begin
						emit = 1'b1;
						if (cls.is_one) begin
							kind_d  = KIND_REC;
							phase_d = PH_NAME_LEN;
							count_d = 8'd0;
						end else begin
							phase_d = PH_ERROR;
						end
					end
				end
				default: begin
					emit    = 1'b1;
					phase_d = PH_ERROR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			count_q     <= 8'd0;
			flen_q      <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				count_q     <= count_d;
				flen_q      <= flen_d;
				out_valid_q <= emit || (out_valid_q && !out_ready);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			kind_q  <= kind_d;
			value_q <= value_d;
			pos_q   <= pos_d;
		end
	end

endmodule

>>> rtl/call_log_frame_parser.sv
// ----------------------------------------------------------------------------
// call_log_frame_parser: byte-serial call-log stream parser
// Front end classifies bytes, a short queue decouples it from the parser
// state machine, which drives a registered result port.
// ----------------------------------------------------------------------------
// The parser takes one byte request per clock cycle and gives at most one
// result per request, so it sustains one request per cycle whenever the
// result side keeps out_ready high. A request that is accepted first lands in
// a QUEUE_DEPTH-entry queue; the state machine drains one entry per cycle
// while its output register is free or being taken, so a result goes
// through the queue and then the output register before it shows on the
// result port. The state machine advances one byte per cycle; that single
// state update sets the rate. Requests that produce no result (header bytes,
// lengths, skipped markers, trailer bytes before the last one) still occupy
// the parser. When the result side stalls, the queue absorbs up to QUEUE_DEPTH
// further requests before in_ready drops. After an error or a clean finish,
// all further requests are accepted and dropped silently until reset. No
// clearing pass follows reset: the block is ready at once.
// ----------------------------------------------------------------------------
module call_log_frame_parser #(
	parameter int unsigned QUEUE_DEPTH = clfp_pkg::QueueDepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_value,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic [7:0] value,
	output logic [7:0] position
);
	import clfp_pkg::*;

	class_t cls_in;
	class_t cls_out;
	logic   q_full;
	logic   q_empty;
	logic   q_push;
	logic   q_pop;

	// A request enters whenever the queue has room.
	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	clfp_front u_front (
		.byte_value   (byte_value),
		.end_of_input (end_of_input),
		.cls          (cls_in)
	);

	clfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (cls_in),
		.pop     (q_pop),
		.rd_data (cls_out),
		.full    (q_full),
		.empty   (q_empty)
	);

	// The parser pops only when its output register is free or being taken.
	clfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (cls_out),
		.avail     (!q_empty),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.value     (value),
		.position  (position)
	);

endmodule

>>> rtl/clfp_checker.sv
// ----------------------------------------------------------------------------
// clfp_checker: port-level checks for the call-log frame parser
// Watches the result port for stalls, the shape of state, date, record-end,
// error and done results, and that no result directly follows a terminal one.
// ----------------------------------------------------------------------------
module clfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] kind,
	input logic [7:0] value,
	input logic [7:0] position
);
	import clfp_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value)
			&& $stable(position))
		else $error("result changed while stalled");

	a_terminal_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (kind == KIND_ERROR || kind == KIND_DONE)
			|=> !out_valid)
		else $error("result after error or done");

	a_state_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_STATE |-> value <= 8'd2 && position == 8'd0)
		else $error("bad call-state result");

	a_empty_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_REC || kind == KIND_ERROR || kind == KIND_DONE)
			|-> value == 8'd0 && position == 8'd0)
		else $error("nonzero payload on record end, error or done");

	a_date_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DATE |-> position < DateLength)
		else $error("date position out of range");

endmodule

bind call_log_frame_parser clfp_checker u_clfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.value     (value),
	.position  (position)
);

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the call-log frame parser
// Builds one long call-log stream (header, a short hand-picked record, then
// random records with skipped markers and every trailer form), ends it with a
// clean finish or a fault, and checks every result against a local parser.
// ----------------------------------------------------------------------------
module tb;

	import clfp_pkg::*;

	// Stream sizes and run limits.
	localparam int unsigned ItemTarget    = 1550;
	localparam int unsigned TailItems     = 150;
	localparam int unsigned WatchdogLimit = 1000;
	localparam int unsigned DrainCycles   = 20;

	// Byte values with a fixed meaning in the stream.
	localparam logic [7:0] HdrByteOne  = 8'd1;
	localparam logic [7:0] HdrByteZero = 8'd0;
	localparam logic [7:0] TrailerEnd  = 8'd1;
	localparam logic [7:0] StateRaw0   = 8'd1;
	localparam logic [7:0] StateRaw1   = 8'd2;
	localparam logic [7:0] StateRaw2   = 8'd3;
	localparam logic [7:0] StateAlt0   = 8'd33;
	localparam logic [7:0] StateAlt1   = 8'd34;
	localparam logic [7:0] StateAlt2   = 8'd35;
	localparam logic [7:0] StateCode0  = 8'd0;
	localparam logic [7:0] StateCode1  = 8'd1;
	localparam logic [7:0] StateCode2  = 8'd2;

	// Where the parser stands in the stream.
	typedef enum logic [3:0] {
		PH_HEADER,
		PH_NAME_LEN,
		PH_NAME,
		PH_STATE,
		PH_STATE_MARK,
		PH_NUM_LEN,
		PH_NUM,
		PH_DATE,
		PH_TRAIL_FIRST,
		PH_TRAIL_MARK,
		PH_TRAIL_SECOND,
		PH_TRAIL_LAST,
		PH_FINISHED,
		PH_FAULT
	} parse_phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic [7:0] position;
	} log_result_t;

	// One request waiting to be sent. When hold is set, the sender waits until
	// every expected result has come back before it offers this request.
	typedef struct packed {
		logic [7:0] data;
		logic       eoi;
		logic       hold;
	} stream_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] byte_value = 8'd0;
	logic       end_of_input = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] kind;
	logic [7:0] value;
	logic [7:0] position;

	stream_item_t pending_bytes[$];
	log_result_t  expected_results[$];

	// Local copy of the parser state, at its reset values.
	parse_phase_t parse_phase = PH_HEADER;
	logic [7:0]   field_index = 8'd0;
	logic [7:0]   field_len = 8'd0;

	log_result_t  predicted;
	log_result_t  oldest_result;
	stream_item_t next_item;
	int unsigned  mismatch_count = 0;
	int unsigned  send_burst = 0;
	int unsigned  send_calm = 0;
	int unsigned  recv_burst = 0;
	int unsigned  recv_calm = 0;
	int unsigned  quiet_cycles = 0;

	call_log_frame_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_value   (byte_value),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.value        (value),
		.position     (position)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Advances the local parser by one request and returns 1 when that request
	// yields a result, which is then left in res.
	function automatic bit parse_byte(input logic [7:0] b, input logic eoi,
		output log_result_t res);
		logic mark;
		logic ok;
		mark = (b[7:4] == MarkerNibble);
		res = '{kind: KIND_ERROR, value: 8'd0, position: 8'd0};
		// Once finished or faulted, the parser stays silent until reset.
		if (parse_phase == PH_FINISHED || parse_phase == PH_FAULT)
			return 1'b0;
		// End of input is only clean right where a new trailer would start,
		// which is the boundary between records.
		if (eoi) begin
			if (parse_phase == PH_TRAIL_FIRST) begin
				parse_phase = PH_FINISHED;
				res.kind = KIND_DONE;
			end else
				parse_phase = PH_FAULT;
			return 1'b1;
		end
		case (parse_phase)
			PH_HEADER: begin
				// Header bytes are compared as they are; a marker value is no
				// exception here.
				case (field_index)
					HdrIdxLead:  ok = (b == HeaderLead);
					HdrIdxOne:   ok = (b == HdrByteOne);
					HdrIdxZero:  ok = (b == HdrByteZero);
					HdrIdxFinal: ok = (b == HdrByteOne);
					default:     ok = 1'b1;
				endcase
				if (!ok) begin
					parse_phase = PH_FAULT;
					return 1'b1;
				end
				field_index = field_index + 8'd1;
				if (field_index >= HeaderLength) begin
					parse_phase = PH_NAME_LEN;
					field_index = 8'd0;
				end
				return 1'b0;
			end
			PH_NAME_LEN, PH_NUM_LEN: begin
				// Any byte is a length, markers included; zero skips the field.
				field_len = b;
				field_index = 8'd0;
				if (parse_phase == PH_NAME_LEN)
					parse_phase = (b != 8'd0) ? PH_NAME : PH_STATE;
				else
					parse_phase = (b != 8'd0) ? PH_NUM : PH_DATE;
				return 1'b0;
			end
			PH_NAME, PH_NUM, PH_DATE: begin
				if (mark)
					return 1'b0;
				res.value = b;
				res.position = field_index;
				field_index = field_index + 8'd1;
				case (parse_phase)
					PH_NAME: begin
						res.kind = KIND_NAME;
						if (field_index >= field_len) begin
							parse_phase = PH_STATE;
							field_index = 8'd0;
						end
					end
					PH_NUM: begin
						res.kind = KIND_NUMBER;
						if (field_index >= field_len) begin
							parse_phase = PH_DATE;
							field_index = 8'd0;
						end
					end
					default: begin
						res.kind = KIND_DATE;
						if (field_index >= DateLength) begin
							parse_phase = PH_TRAIL_FIRST;
							field_index = 8'd0;
						end
					end
				endcase
				return 1'b1;
			end
			PH_STATE, PH_STATE_MARK: begin
				// A single marker may precede the state byte; a second one
				// falls through to the decode below and faults.
				if (mark && parse_phase == PH_STATE) begin
					parse_phase = PH_STATE_MARK;
					return 1'b0;
				end
				res.kind = KIND_STATE;
				case (b)
					StateRaw0, StateAlt0: res.value = StateCode0;
					StateRaw1, StateAlt1: res.value = StateCode1;
					StateRaw2, StateAlt2: res.value = StateCode2;
					default: begin
						res.kind = KIND_ERROR;
						parse_phase = PH_FAULT;
						return 1'b1;
					end
				endcase
				parse_phase = PH_NUM_LEN;
				field_index = 8'd0;
				return 1'b1;
			end
			PH_TRAIL_FIRST: begin
				parse_phase = mark ? PH_TRAIL_MARK : PH_TRAIL_SECOND;
				return 1'b0;
			end
			PH_TRAIL_MARK: begin
				// After a leading marker, the next byte is taken whatever it is.
				parse_phase = PH_TRAIL_LAST;
				return 1'b0;
			end
			PH_TRAIL_SECOND, PH_TRAIL_LAST: begin
				if (mark && parse_phase == PH_TRAIL_SECOND) begin
					parse_phase = PH_TRAIL_LAST;
					return 1'b0;
				end
				if (b != TrailerEnd) begin
					parse_phase = PH_FAULT;
					return 1'b1;
				end
				res.kind = KIND_REC;
				parse_phase = PH_NAME_LEN;
				field_index = 8'd0;
				return 1'b1;
			end
			default: begin
				parse_phase = PH_FAULT;
				return 1'b1;
			end
		endcase
	endfunction

	function automatic logic [7:0] any_plain();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b[7:4] == MarkerNibble);
		return b;
	endfunction

	function automatic logic [7:0] any_marker();
		return {MarkerNibble, 4'($urandom_range(0, 15))};
	endfunction

	// Mostly short fields, some empty, and now and then one near the maximum.
	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(0, 199);
		if (r < 30)
			return 0;
		if (r < 180)
			return $urandom_range(1, 8);
		if (r < 197)
			return $urandom_range(9, 40);
		return $urandom_range(200, 255);
	endfunction

	// Idle pattern shared by both sides: bursts of idle cycles,
	// broken up by calm stretches with no idling at all.
	function automatic bit pick_idle(inout int unsigned burst, inout int unsigned calm);
		if (burst != 0) begin
			burst--;
			return 1'b1;
		end
		if (calm != 0) begin
			calm--;
			return 1'b0;
		end
		if ($urandom_range(0, 9) == 0)
			calm = $urandom_range(20, 60);
		else if ($urandom_range(0, 3) == 0) begin
			burst = $urandom_range(0, 3);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic push_item(input logic [7:0] b, input logic eoi, input logic hold);
		pending_bytes.push_back('{data: b, eoi: eoi, hold: hold});
	endtask

	// Plain characters with a skipped marker now and then in front of one.
	task automatic push_text(input int unsigned count);
		repeat (count) begin
			if ($urandom_range(0, 7) == 0)
				push_item(any_marker(), 1'b0, 1'b0);
			push_item(any_plain(), 1'b0, 1'b0);
		end
	endtask

	task automatic add_record(input logic hold_first);
		int unsigned len;
		logic [7:0]  state_byte;
		len = pick_length();
		push_item(8'(len), 1'b0, hold_first);
		push_text(len);
		if ($urandom_range(0, 3) == 0)
			push_item(any_marker(), 1'b0, 1'b0);
		case ($urandom_range(0, 5))
			0:       state_byte = StateRaw0;
			1:       state_byte = StateRaw1;
			2:       state_byte = StateRaw2;
			3:       state_byte = StateAlt0;
			4:       state_byte = StateAlt1;
			default: state_byte = StateAlt2;
		endcase
		push_item(state_byte, 1'b0, 1'b0);
		len = pick_length();
		push_item(8'(len), 1'b0, 1'b0);
		push_text(len);
		push_text(32'(DateLength));
		// The three trailer shapes: plain then end, plain then marker then end,
		// and leading marker then any byte then end.
		case ($urandom_range(0, 2))
			0: begin
				push_item(any_plain(), 1'b0, 1'b0);
			end
			1: begin
				push_item(any_plain(), 1'b0, 1'b0);
				push_item(any_marker(), 1'b0, 1'b0);
			end
			default: begin
				push_item(any_marker(), 1'b0, 1'b0);
				push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
		endcase
		push_item(TrailerEnd, 1'b0, 1'b0);
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	// Sender. At each edge it first retires an accepted request into the local
	// parser, then decides what to offer next. A request that is on the port
	// and not yet taken is left alone, so valid and payload stay put.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			byte_value <= 8'd0;
			end_of_input <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				if (parse_byte(byte_value, end_of_input, predicted))
					expected_results.push_back(predicted);
			end
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() != 0
						&& !(pending_bytes[0].hold && expected_results.size() != 0)
						&& !(pending_bytes.size() >= TailItems
							&& pick_idle(send_burst, send_calm))) begin
					next_item = pending_bytes.pop_front();
					in_valid <= 1'b1;
					byte_value <= next_item.data;
					end_of_input <= next_item.eoi;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Receiver. Checks each accepted result against the oldest expectation
	// and stalls in bursts, except over the last stretch of the run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0)
					report_mismatch($sformatf("unexpected result kind %0d value %0d position %0d",
						kind, value, position));
				else begin
					oldest_result = expected_results.pop_front();
					if (kind !== oldest_result.kind)
						report_mismatch($sformatf("kind %0d, expected %0d",
							kind, oldest_result.kind));
					if (value !== oldest_result.value)
						report_mismatch($sformatf("value %0d, expected %0d (kind %0d)",
							value, oldest_result.value, oldest_result.kind));
					if (position !== oldest_result.position)
						report_mismatch($sformatf("position %0d, expected %0d (kind %0d)",
							position, oldest_result.position, oldest_result.kind));
				end
			end
			out_ready <= (pending_bytes.size() < TailItems) || !pick_idle(recv_burst, recv_calm);
		end
	end

	// Watchdog: ends the run when no request and no result has moved for too
	// long, which also catches results that never arrive.
	initial begin
		while (quiet_cycles < WatchdogLimit) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout after %0d quiet cycles", WatchdogLimit);
		$display("tb failed");
		$finish;
	end

	initial begin
		// Header. The two free bytes carry a marker value and all ones, which
		// must not be taken as markers.
		push_item(HeaderLead, 1'b0, 1'b0);
		push_item(HdrByteOne, 1'b0, 1'b0);
		push_item(8'hd7, 1'b0, 1'b0);
		push_item(HdrByteZero, 1'b0, 1'b0);
		push_item(8'hff, 1'b0, 1'b0);
		push_item(HdrByteOne, 1'b0, 1'b0);

		// Hand-picked record: extreme name characters around a skipped marker,
		// a marker before the state, an empty number, a date with a marker
		// inside, and a trailer that opens with a marker followed by another.
		push_item(8'd2, 1'b0, 1'b0);
		push_item(8'h00, 1'b0, 1'b0);
		push_item(8'hd0, 1'b0, 1'b0);
		push_item(8'hff, 1'b0, 1'b0);
		push_item(8'hdf, 1'b0, 1'b0);
		push_item(StateAlt2, 1'b0, 1'b0);
		push_item(8'd0, 1'b0, 1'b0);
		push_item(8'h7f, 1'b0, 1'b0);
		push_item(8'hdd, 1'b0, 1'b0);
		push_item(8'h80, 1'b0, 1'b0);
		push_item(8'h00, 1'b0, 1'b0);
		push_item(8'hff, 1'b0, 1'b0);
		push_item(8'h01, 1'b0, 1'b0);
		push_item(8'hc9, 1'b0, 1'b0);
		push_item(8'hd3, 1'b0, 1'b0);
		push_item(8'hd4, 1'b0, 1'b0);
		push_item(TrailerEnd, 1'b0, 1'b0);

		// Random well-formed records. Every twentieth one waits for all
		// outstanding results before its first byte goes out.
		for (int unsigned rec = 0; pending_bytes.size() < ItemTarget; rec++)
			add_record(rec % 20 == 0);

		// Close the stream: half the time a clean finish, otherwise one of the ways
		// it can go wrong.
		case ($urandom_range(0, 5))
			3: begin
				// End of input in the middle of a name.
				push_item(8'd2, 1'b0, 1'b0);
				push_item(any_plain(), 1'b0, 1'b0);
				push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
			end
			4: begin
				// A marker, then a byte that is no state: a second marker or an
				// unknown code.
				push_item(8'd0, 1'b0, 1'b0);
				push_item(any_marker(), 1'b0, 1'b0);
				if ($urandom_range(0, 1) == 0)
					push_item(any_marker(), 1'b0, 1'b0);
				else
					push_item(8'($urandom_range(36, 207)), 1'b0, 1'b0);
			end
			5: begin
				// A record whose trailer does not end in the end byte.
				push_item(8'd0, 1'b0, 1'b0);
				push_item(StateRaw0, 1'b0, 1'b0);
				push_item(8'd0, 1'b0, 1'b0);
				push_text(32'(DateLength));
				push_item(any_plain(), 1'b0, 1'b0);
				push_item(8'($urandom_range(2, 207)), 1'b0, 1'b0);
			end
			default:
				push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
		endcase

		// Requests after the end are taken and dropped without a result.
		repeat (6)
			push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);

		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles)
			@(posedge clk);

		if (mismatch_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
